// ===== hdl/chrb_pkg.sv =====
// Shared constants and types for the consistent-hash range builder.
package chrb_pkg;

  localparam int MAX_SWITCHES = 16;
  localparam int SW_IDX_W     = $clog2(MAX_SWITCHES);
  localparam int SW_CNT_W     = $clog2(MAX_SWITCHES + 1);
  localparam int HASH_W       = 16;
  localparam int WORD_W       = 32;
  localparam int ADDR_W       = 4;

  localparam logic [HASH_W-1:0] RING_TOP = 16'hffff;

  localparam logic [WORD_W-1:0] MUR_C1   = 32'hcc9e2d51;
  localparam logic [WORD_W-1:0] MUR_C2   = 32'h1b873593;
  localparam logic [WORD_W-1:0] MUR_M5   = 32'd5;
  localparam logic [WORD_W-1:0] MUR_ADD  = 32'he6546b64;
  localparam logic [WORD_W-1:0] MUR_LEN  = 32'd4;
  localparam logic [WORD_W-1:0] MUR_F1   = 32'h85ebca6b;
  localparam logic [WORD_W-1:0] MUR_F2   = 32'hc2b2ae35;

  localparam logic [SW_CNT_W-1:0] NUM_SW_RESET = SW_CNT_W'(4);
  localparam logic [WORD_W-1:0]   SEED_RESET   = 32'd100;

  typedef enum logic [1:0] {
    REG_NUM_SWITCHES = 2'd0,
    REG_SEED_BASE    = 2'd1,
    REG_SEED_STEP    = 2'd2
  } reg_idx_t;

endpackage

// ===== hdl/consistent_hash_range_builder.sv =====
// Top level: sequencer for ring hashing and range emission per flow request.
// Each request hashes every switch onto the ring (states S_K1 to S_K8 per switch, five
//   products on the shared multiplier), then emits its ranges; output stalls hold emission.
//   A new request is taken only once the last range of the current one has been emitted;
//   the successor scan reads one stored hash per cycle.
// Reset: synchronous, active low; num_switches = 4, seed_base = seed_step = 100,
//   flow count zero, idle. The ring position store is not cleared.
module consistent_hash_range_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_src_ip,
  input  logic [31:0] in_dst_ip,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_switch_id,
  output logic [31:0] out_src_ip,
  output logic [31:0] out_dst_ip,
  output logic [15:0] out_span_start,
  output logic [15:0] out_span_stop,
  output logic        out_last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int WW = chrb_pkg::WORD_W;
  localparam int HW = chrb_pkg::HASH_W;
  localparam int IW = chrb_pkg::SW_IDX_W;
  localparam int CW = chrb_pkg::SW_CNT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SEED, S_SEED_W, S_K1, S_K2, S_K3, S_K4, S_K5, S_K6, S_K7, S_K8,
    S_RD, S_CUR, S_SCAN, S_ENORM, S_ETOP
  } state_t;

  typedef enum logic {
    W_NONE, W_PEND
  } wrap_t;

  function automatic logic [WW-1:0] rotl(input logic [WW-1:0] x, input int unsigned r);
    return (x << r) | (x >> (WW - r));
  endfunction

  // configuration registers
  logic [CW-1:0] nsw_r;
  logic [WW-1:0] sbase_r;
  logic [WW-1:0] sstep_r;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nsw_r   <= chrb_pkg::NUM_SW_RESET;
      sbase_r <= chrb_pkg::SEED_RESET;
      sstep_r <= chrb_pkg::SEED_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        chrb_pkg::REG_NUM_SWITCHES: nsw_r   <= pwdata[CW-1:0];
        chrb_pkg::REG_SEED_BASE:    sbase_r <= pwdata;
        chrb_pkg::REG_SEED_STEP:    sstep_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      chrb_pkg::REG_NUM_SWITCHES: prdata = WW'(nsw_r);
      chrb_pkg::REG_SEED_BASE:    prdata = sbase_r;
      chrb_pkg::REG_SEED_STEP:    prdata = sstep_r;
      default:                    prdata = '0;
    endcase
  end

  // sequencer registers
  state_t        state_r, state_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic          cmp_v_r, cmp_v_nxt;
  logic          wrap_done_r, wrap_done_nxt;
  wrap_t         top_r, top_nxt;
  logic [WW-1:0] seed_r, seed_nxt;
  logic [WW-1:0] h_r, h_nxt;
  logic [WW-1:0] flow_cnt_r, flow_cnt_nxt;
  logic [HW-1:0] lo_r, lo_nxt;
  logic [HW-1:0] hi_r, hi_nxt;
  logic [HW-1:0] cur_r, cur_nxt;
  logic [HW-1:0] next_r, next_nxt;
  logic [WW-1:0] src_r, src_nxt;
  logic [WW-1:0] dst_r, dst_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [IW-1:0] o_id_r, o_id_nxt;
  logic [HW-1:0] o_beg_r, o_beg_nxt;
  logic [HW-1:0] o_end_r, o_end_nxt;
  logic          o_last_r, o_last_nxt;
  logic [WW-1:0] o_src_r, o_src_nxt;
  logic [WW-1:0] o_dst_r, o_dst_nxt;

  logic [WW-1:0] mul_a, mul_b, mul_p;
  logic          ram_we;
  logic [IW-1:0] ram_raddr;
  logic [HW-1:0] ram_rdata;
  logic [HW-1:0] hash16;
  logic [CW-1:0] n_clamp;
  logic          last_i;
  logic          out_free;
  logic          advance;

  chrb_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  chrb_ram #(
    .WIDTH (HW),
    .DEPTH (chrb_pkg::MAX_SWITCHES)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (i_r),
    .wdata (hash16),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign hash16   = mul_p[HW-1:0] ^ mul_p[WW-1:HW];
  assign last_i   = ({1'b0, i_r} == CW'(n_r - CW'(1)));
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    if (nsw_r == '0) begin
      n_clamp = CW'(1);
    end else if (nsw_r > CW'(chrb_pkg::MAX_SWITCHES)) begin
      n_clamp = CW'(chrb_pkg::MAX_SWITCHES);
    end else begin
      n_clamp = nsw_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    cmp_v_nxt     = cmp_v_r;
    wrap_done_nxt = wrap_done_r;
    top_nxt       = top_r;
    seed_nxt      = seed_r;
    h_nxt         = h_r;
    flow_cnt_nxt  = flow_cnt_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    cur_nxt       = cur_r;
    next_nxt      = next_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    out_valid_nxt = out_valid_r && out_stall;
    o_id_nxt      = o_id_r;
    o_beg_nxt     = o_beg_r;
    o_end_nxt     = o_end_r;
    o_last_nxt    = o_last_r;
    o_src_nxt     = o_src_r;
    o_dst_nxt     = o_dst_r;
    mul_a         = '0;
    mul_b         = '0;
    ram_we        = 1'b0;
    ram_raddr     = i_r;
    advance       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          src_nxt   = in_src_ip;
          dst_nxt   = in_dst_ip;
          n_nxt     = n_clamp;
          state_nxt = S_SEED;
        end
      end
      S_SEED: begin
        mul_a         = flow_cnt_r;
        mul_b         = sstep_r;
        lo_nxt        = chrb_pkg::RING_TOP;
        hi_nxt        = '0;
        i_nxt         = '0;
        wrap_done_nxt = 1'b0;
        state_nxt     = S_SEED_W;
      end
      S_SEED_W: begin
        seed_nxt  = mul_p + sbase_r;
        state_nxt = S_K1;
      end
      S_K1: begin
        mul_a     = WW'(i_r);
        mul_b     = chrb_pkg::MUR_C1;
        state_nxt = S_K2;
      end
      S_K2: begin
        mul_a     = rotl(mul_p, 15);
        mul_b     = chrb_pkg::MUR_C2;
        state_nxt = S_K3;
      end
      S_K3: begin
        h_nxt     = rotl(seed_r ^ mul_p, 13);
        state_nxt = S_K4;
      end
      S_K4: begin
        mul_a     = h_r;
        mul_b     = chrb_pkg::MUR_M5;
        state_nxt = S_K5;
      end
      S_K5: begin
        h_nxt     = (mul_p + chrb_pkg::MUR_ADD) ^ chrb_pkg::MUR_LEN;
        state_nxt = S_K6;
      end
      S_K6: begin
        mul_a     = h_r ^ (h_r >> 16);
        mul_b     = chrb_pkg::MUR_F1;
        state_nxt = S_K7;
      end
      S_K7: begin
        mul_a     = mul_p ^ (mul_p >> 13);
        mul_b     = chrb_pkg::MUR_F2;
        state_nxt = S_K8;
      end
      S_K8: begin
        ram_we = 1'b1;
        if (hash16 < lo_r) begin
          lo_nxt = hash16;
        end
        if (hash16 > hi_r) begin
          hi_nxt = hash16;
        end
        if (last_i) begin
          i_nxt     = '0;
          state_nxt = S_RD;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = S_K1;
        end
      end
      S_RD: begin
        ram_raddr = i_r;
        state_nxt = S_CUR;
      end
      S_CUR: begin
        cur_nxt = ram_rdata;
        if (ram_rdata == hi_r) begin
          top_nxt   = W_NONE;
          state_nxt = S_ETOP;
        end else begin
          next_nxt  = hi_r;
          j_nxt     = '0;
          cmp_v_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cmp_v_r && ram_rdata > cur_r && ram_rdata < next_r) begin
          next_nxt = ram_rdata;
        end
        if (j_r != n_r) begin
          ram_raddr = j_r[IW-1:0];
          j_nxt     = j_r + CW'(1);
          cmp_v_nxt = 1'b1;
        end else begin
          cmp_v_nxt = 1'b0;
          state_nxt = S_ENORM;
        end
      end
      S_ENORM: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_id_nxt      = i_r;
          o_beg_nxt     = cur_r;
          o_end_nxt     = next_r;
          o_last_nxt    = last_i;
          o_src_nxt     = src_r;
          o_dst_nxt     = dst_r;
          advance       = 1'b1;
        end
      end
      S_ETOP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_id_nxt      = i_r;
          o_src_nxt     = src_r;
          o_dst_nxt     = dst_r;
          if (top_r == W_PEND) begin
            // wrap range, second result of the first top switch
            o_beg_nxt  = '0;
            o_end_nxt  = lo_r;
            o_last_nxt = last_i;
            advance    = 1'b1;
          end else begin
            o_beg_nxt  = cur_r;
            o_end_nxt  = chrb_pkg::RING_TOP;
            o_last_nxt = last_i && wrap_done_r;
            if (wrap_done_r) begin
              advance = 1'b1;
            end else begin
              wrap_done_nxt = 1'b1;
              top_nxt       = W_PEND;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (advance) begin
      if (last_i) begin
        flow_cnt_nxt = flow_cnt_r + WW'(1);
        state_nxt    = S_IDLE;
      end else begin
        i_nxt     = i_r + IW'(1);
        state_nxt = S_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      flow_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      cmp_v_r     <= 1'b0;
      wrap_done_r <= 1'b0;
      top_r       <= W_NONE;
      n_r         <= CW'(1);
      i_r         <= '0;
      j_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      flow_cnt_r  <= flow_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_v_r     <= cmp_v_nxt;
      wrap_done_r <= wrap_done_nxt;
      top_r       <= top_nxt;
      n_r         <= n_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
    end
    seed_r   <= seed_nxt;
    h_r      <= h_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    cur_r    <= cur_nxt;
    next_r   <= next_nxt;
    src_r    <= src_nxt;
    dst_r    <= dst_nxt;
    o_id_r   <= o_id_nxt;
    o_beg_r  <= o_beg_nxt;
    o_end_r  <= o_end_nxt;
    o_last_r <= o_last_nxt;
    o_src_r  <= o_src_nxt;
    o_dst_r  <= o_dst_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_switch_id   = o_id_r;
  assign out_src_ip      = o_src_r;
  assign out_dst_ip      = o_dst_r;
  assign out_span_start  = o_beg_r;
  assign out_span_stop   = o_end_r;
  assign out_last_of_run = o_last_r;

  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> o_beg_r <= o_end_r)
    else $error("range begin above range end");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted without going busy");

  a_ring_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_ENORM || state_r == S_ETOP) |-> lo_r <= hi_r)
    else $error("smallest ring position above greatest");

  a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (j_r <= n_r && n_r != '0))
    else $error("scan index past switch count");

  a_wrap_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ETOP && top_r == W_PEND) |-> wrap_done_r)
    else $error("wrap range pending without top switch seen");

endmodule

// ===== hdl/chrb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module chrb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/chrb_mul.sv =====
// Shared 32x32 multiplier, low word of the product registered.
module chrb_mul (
  input  logic                       clk,
  input  logic [chrb_pkg::WORD_W-1:0] a,
  input  logic [chrb_pkg::WORD_W-1:0] b,
  output logic [chrb_pkg::WORD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= chrb_pkg::WORD_W'(a * b);
  end

endmodule
